@@ src/osr_pkg.sv @@
// ----------------------------------------------------------------------------
// osr_pkg: shared types and codes for the order-statistic set
// Request kinds, result status codes and the control bundle that the top
// level drives into every cell of the sorted chain.
// ----------------------------------------------------------------------------
package osr_pkg;

   localparam int REQ_KEY_BITS = 32;
   localparam int OP_BITS      = 2;
   localparam int STATUS_BITS  = 2;

   localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_BITS-1:0] OP_QUERY  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_DONE     = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_NOEFFECT = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd2;

   // Per-cycle command to the cell chain
   typedef struct packed {
      logic compare;   // register less-than / equal flags against the probe key
      logic insert;    // open a slot at the insertion point and shift right
      logic remove;    // close the matching slot and shift left
   } osr_ctrl_type;

endpackage

@@ src/osr_cell.sv @@
// ----------------------------------------------------------------------------
// osr_cell: one slot of the sorted key chain
// Holds one key, compares it against the broadcast probe key and shifts
// keys with its neighbours on insert or remove.
// ----------------------------------------------------------------------------
module osr_cell #(
   parameter int KEY_BITS   = 32,
   parameter int COUNT_BITS = 9,
   parameter int INDEX      = 0
) (
   input  logic                        clock,
   input  osr_pkg::osr_ctrl_type       ctrl,
   input  logic signed [KEY_BITS-1:0]  probe_key,
   input  logic [COUNT_BITS-1:0]       count,
   input  logic signed [KEY_BITS-1:0]  left_key,
   input  logic                        left_lt,
   input  logic signed [KEY_BITS-1:0]  right_key,
   output logic signed [KEY_BITS-1:0]  store_key,
   output logic                        lt,
   output logic                        eq
);
   import osr_pkg::*;

   localparam logic [COUNT_BITS-1:0] SLOT = COUNT_BITS'(INDEX);

   logic signed [KEY_BITS-1:0] key_ff, key_in;
   logic                       lt_ff, eq_ff;
   logic                       occupied;

   assign occupied = SLOT < count;

   // Cells below the insertion point keep their key; the rest move one place.
   always_comb begin
      key_in = key_ff;
      if (ctrl.insert && !lt_ff) begin
         key_in = left_lt ? probe_key : left_key;
      end else if (ctrl.remove && !lt_ff) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (ctrl.compare) begin
         lt_ff <= occupied && (key_ff < probe_key);
         eq_ff <= occupied && (key_ff == probe_key);
      end
   end

   assign store_key = key_ff;
   assign lt        = lt_ff;
   assign eq        = eq_ff;

endmodule

@@ src/osr_enc.sv @@
// ----------------------------------------------------------------------------
// osr_enc: match encoder
// Turns the one-hot equal flags of the chain into a hit flag and the slot
// index of the match.
// ----------------------------------------------------------------------------
module osr_enc #(
   parameter int CAPACITY   = 256,
   parameter int INDEX_BITS = 8
) (
   input  logic [CAPACITY-1:0]   eq,
   output logic                  hit,
   output logic [INDEX_BITS-1:0] index
);
   import osr_pkg::*;

   assign hit = |eq;

   // At most one flag is set (keys are distinct), so an OR per index bit works.
   always_comb begin
      index = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (eq[i]) begin
            index = index | INDEX_BITS'(i);
         end
      end
   end

endmodule

@@ src/order_statistic_set_rank_top.sv @@
// ----------------------------------------------------------------------------
// order_statistic_set_rank_top: sorted set with rank query
// Each request passes through the compare, resolve and update phases of the
// cell chain, and its result strobe is out in the update phase; no new request
// is taken during compare or resolve, but one may be taken during update.
// Reset: synchronous, empties the set; stored key values need no clearing.
// The result strobe cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module order_statistic_set_rank_top #(
   parameter int CAPACITY = 256,
   parameter int KEY_BITS = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic [osr_pkg::OP_BITS-1:0]               req_op,
   input  logic signed [osr_pkg::REQ_KEY_BITS-1:0]   req_key,
   output logic                                      rsp_valid,
   output logic [$clog2(CAPACITY+1)-1:0]             rsp_rank,
   output logic [osr_pkg::STATUS_BITS-1:0]           rsp_status
);
   import osr_pkg::*;

   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int INDEX_BITS = $clog2(CAPACITY);
   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(CAPACITY);

   // Request flow:
   //   IDLE    - waiting for a request
   //   COMPARE - every cell compares its key with the probe key in parallel
   //   RESOLVE - hit flag, match slot, rank and status are worked out
   //   UPDATE  - cells shift on insert/remove, result strobe is out;
   //             the next request may be taken here
   typedef enum logic [1:0] {
      IDLE,
      COMPARE,
      RESOLVE,
      UPDATE
   } state_type;

   state_type                     state_ff;
   logic [OP_BITS-1:0]            op_ff;
   logic signed [KEY_BITS-1:0]    key_ff;
   logic signed [KEY_BITS-1:0]    key_in;
   logic [COUNT_BITS-1:0]         count_ff;
   logic                          insert_ff, remove_ff;
   logic                          rsp_valid_ff;
   logic [COUNT_BITS-1:0]         rank_ff;
   logic [STATUS_BITS-1:0]        status_ff;

   osr_ctrl_type                  ctrl;
   logic signed [KEY_BITS-1:0]    cell_key [CAPACITY];
   logic [CAPACITY-1:0]           cell_lt, cell_eq;
   logic                          hit;
   logic [INDEX_BITS-1:0]         hit_index;
   logic                          take;

   // Probe key: low KEY_BITS of the request key, raw upper bits as zero.
   generate
      if (KEY_BITS <= REQ_KEY_BITS) begin : g_key_narrow
         assign key_in = req_key[KEY_BITS-1:0];
      end else begin : g_key_wide
         assign key_in = {{(KEY_BITS-REQ_KEY_BITS){1'b0}}, req_key};
      end
   endgenerate

   assign busy = (state_ff == COMPARE) || (state_ff == RESOLVE);
   assign take = start && !busy;

   assign ctrl.compare = (state_ff == COMPARE);
   assign ctrl.insert  = insert_ff;
   assign ctrl.remove  = remove_ff;

   // Chain of cells: slot 0 holds the smallest key. Each cell sees its
   // left neighbour (for insert shifts) and its right neighbour (for removes).
   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         logic signed [KEY_BITS-1:0] left_key, right_key;
         logic                       left_lt;
         if (i == 0) begin : g_first
            assign left_key = key_ff;
            assign left_lt  = 1'b1;   // slot 0 takes the probe key on insert
         end else begin : g_inner
            assign left_key = cell_key[i-1];
            assign left_lt  = cell_lt[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign right_key = key_ff;  // slot falls out of range after remove
         end else begin : g_body
            assign right_key = cell_key[i+1];
         end

         osr_cell #(
            .KEY_BITS   (KEY_BITS),
            .COUNT_BITS (COUNT_BITS),
            .INDEX      (i)
         ) u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .probe_key (key_ff),
            .count     (count_ff),
            .left_key  (left_key),
            .left_lt   (left_lt),
            .right_key (right_key),
            .store_key (cell_key[i]),
            .lt        (cell_lt[i]),
            .eq        (cell_eq[i])
         );
      end
   endgenerate

   osr_enc #(
      .CAPACITY   (CAPACITY),
      .INDEX_BITS (INDEX_BITS)
   ) u_enc (
      .eq    (cell_eq),
      .hit   (hit),
      .index (hit_index)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         insert_ff    <= 1'b0;
         remove_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (take) begin
                  op_ff    <= req_op;
                  key_ff   <= key_in;
                  state_ff <= COMPARE;
               end
            end
            COMPARE: begin
               state_ff <= RESOLVE;
            end
            RESOLVE: begin
               rsp_valid_ff <= 1'b1;
               case (op_ff)
                  OP_INSERT: begin
                     rank_ff <= '0;
                     if (hit) begin
                        status_ff <= ST_NOEFFECT;
                     end else if (count_ff == FULL_COUNT) begin
                        status_ff <= ST_FULL;
                     end else begin
                        status_ff <= ST_DONE;
                        insert_ff <= 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     if (hit) begin
                        rank_ff   <= COUNT_BITS'(hit_index) + COUNT_BITS'(1);
                        status_ff <= ST_DONE;
                     end else begin
                        rank_ff   <= '0;
                        status_ff <= ST_NOEFFECT;
                     end
                  end
                  OP_REMOVE: begin
                     rank_ff <= '0;
                     if (hit) begin
                        status_ff <= ST_DONE;
                        remove_ff <= 1'b1;
                     end else begin
                        status_ff <= ST_NOEFFECT;
                     end
                  end
                  default: begin
                     rank_ff   <= '0;
                     status_ff <= ST_NOEFFECT;
                  end
               endcase
               state_ff <= UPDATE;
            end
            UPDATE: begin
               // cells shift at this edge; keep the count in step
               if (insert_ff) begin
                  count_ff <= count_ff + COUNT_BITS'(1);
               end else if (remove_ff) begin
                  count_ff <= count_ff - COUNT_BITS'(1);
               end
               insert_ff    <= 1'b0;
               remove_ff    <= 1'b0;
               rsp_valid_ff <= 1'b0;
               if (take) begin
                  op_ff    <= req_op;
                  key_ff   <= key_in;
                  state_ff <= COMPARE;
               end else begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_rank   = rank_ff;
   assign rsp_status = status_ff;

endmodule
